// ----- rtl/fwdf_pkg.sv -----
// fwdf_pkg: shared types and constants for the fixed-width decimal formatter
// transaction structs, operation codes, divisors and reciprocal multipliers
// no dependencies
package fwdf_pkg;

   // operation codes; the fourth code has no meaning and yields no result
   localparam logic [1:0] OP_TWO   = 2'd0;
   localparam logic [1:0] OP_FOUR  = 2'd1;
   localparam logic [1:0] OP_EIGHT = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // character counts reported per operation
   localparam logic [3:0] COUNT_TWO   = 4'd2;
   localparam logic [3:0] COUNT_FOUR  = 4'd4;
   localparam logic [3:0] COUNT_EIGHT = 4'd8;

   localparam logic [7:0] ASCII_ZERO = 8'd48;

   // divisors
   localparam logic [13:0] HALF_DIV  = 14'd10000;
   localparam logic [6:0]  PAIR_DIV  = 7'd100;
   localparam logic [3:0]  DIGIT_DIV = 4'd10;

   // floor(2^45 / 10000): quotient is exact or one low, fixed by a compare
   localparam logic [31:0] HALF_RECIP = 32'd3518437208;
   localparam int          HALF_SHIFT = 45;
   // ceil(2^23 / 100): exact for any 16-bit dividend
   localparam logic [16:0] PAIR_RECIP = 17'd83887;
   localparam int          PAIR_SHIFT = 23;
   // (x * 205) >> 11 is exact x / 10 for any byte
   localparam logic [7:0]  DIGIT_RECIP = 8'd205;
   localparam int          DIGIT_SHIFT = 11;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_0;
      logic [7:0] char_1;
      logic [7:0] char_2;
      logic [7:0] char_3;
      logic [7:0] char_4;
      logic [7:0] char_5;
      logic [7:0] char_6;
      logic [7:0] char_7;
      logic [3:0] char_count;
   } rsp_type;

endpackage

// ----- rtl/fixed_width_decimal_formatter.sv -----
// fixed_width_decimal_formatter: binary to 2, 4 or 8 ASCII decimal characters
// seven-stage pipeline, single module
// depends on fwdf_pkg for the transaction structs and constants
//
// Usage: a transaction is taken on every clock edge with start high; busy is
// never raised, so one value may be issued each cycle. Each result appears on
// rsp_data for exactly one cycle, marked by rsp_strobe, in request order; the
// receiver must take it then. A request with the unused operation code
// produces no result. The pipeline depth is set by the chain of reciprocal
// multiplies: the split by 10000 (a 32x32 multiply, a back-multiply and a
// correcting compare), the split by 100 and the split by ten, each multiply
// followed by a register.
module fixed_width_decimal_formatter
   import fwdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // stage 1: reciprocal multiply for the split by 10000
   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic [31:0] s1_value_ff;
   logic [18:0] s1_quot_ff;
   logic [63:0] half_prod;
   logic        req_take;

   assign busy     = 1'b0;
   assign req_take = start && (req_data.operation != OP_NONE);
   assign half_prod = {32'b0, req_data.value} * {32'b0, HALF_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take;
      end
      s1_op_ff    <= req_data.operation;
      s1_value_ff <= req_data.value;
      s1_quot_ff  <= half_prod[HALF_SHIFT+18:HALF_SHIFT];
   end

   // stage 2: back-multiply and raw remainder
   logic        s2_valid_ff;
   logic [1:0]  s2_op_ff;
   logic [31:0] s2_value_ff;
   logic [18:0] s2_quot_ff;
   logic [14:0] s2_rem_ff;
   logic [32:0] half_back;
   logic [31:0] half_rem_raw;

   assign half_back    = {14'b0, s1_quot_ff} * 33'(HALF_DIV);
   assign half_rem_raw = s1_value_ff - half_back[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_op_ff    <= s1_op_ff;
      s2_value_ff <= s1_value_ff;
      s2_quot_ff  <= s1_quot_ff;
      s2_rem_ff   <= half_rem_raw[14:0];
   end

   // stage 3: correct the estimate and pick the four-digit operands
   logic        s3_valid_ff;
   logic [1:0]  s3_op_ff;
   logic [31:0] s3_quad_a_ff;
   logic [13:0] s3_quad_b_ff;
   logic [31:0] quad_a_in;
   logic [13:0] quad_b_in;
   logic [18:0] half_quot;
   logic [13:0] half_rem;

   always_comb begin
      if (s2_rem_ff >= 15'(HALF_DIV)) begin
         half_quot = s2_quot_ff + 19'd1;
         half_rem  = 14'(s2_rem_ff - 15'(HALF_DIV));
      end else begin
         half_quot = s2_quot_ff;
         half_rem  = s2_rem_ff[13:0];
      end
      if (s2_op_ff != OP_EIGHT) begin
         quad_a_in = s2_value_ff;
         quad_b_in = '0;
      end else if (s2_value_ff < 32'(HALF_DIV)) begin
         quad_a_in = '0;
         quad_b_in = s2_value_ff[13:0];
      end else begin
         quad_a_in = {13'b0, half_quot};
         quad_b_in = half_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_op_ff     <= s2_op_ff;
      s3_quad_a_ff <= quad_a_in;
      s3_quad_b_ff <= quad_b_in;
   end

   // stage 4: quotients of the split by 100 for both four-digit groups
   logic        s4_valid_ff;
   logic [1:0]  s4_op_ff;
   logic        s4_a_small_ff, s4_b_small_ff;
   logic [15:0] s4_a_x_ff, s4_b_x_ff;
   logic [9:0]  s4_a_quot_ff, s4_b_quot_ff;
   logic [32:0] pair_prod_a, pair_prod_b;

   assign pair_prod_a = {17'b0, s3_quad_a_ff[15:0]} * {16'b0, PAIR_RECIP};
   assign pair_prod_b = {19'b0, s3_quad_b_ff} * {16'b0, PAIR_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_op_ff      <= s3_op_ff;
      s4_a_small_ff <= s3_quad_a_ff < 32'(PAIR_DIV);
      s4_b_small_ff <= s3_quad_b_ff < 14'(PAIR_DIV);
      s4_a_x_ff     <= s3_quad_a_ff[15:0];
      s4_b_x_ff     <= {2'b0, s3_quad_b_ff};
      s4_a_quot_ff  <= pair_prod_a[PAIR_SHIFT+9:PAIR_SHIFT];
      s4_b_quot_ff  <= pair_prod_b[PAIR_SHIFT+9:PAIR_SHIFT];
   end

   // stage 5: remainders of the split by 100, forming the digit pairs
   logic        s5_valid_ff;
   logic [1:0]  s5_op_ff;
   logic [15:0] s5_pair_ff [4];
   logic [15:0] pair_in [4];
   logic [15:0] back_a, back_b;
   logic [15:0] rem_a, rem_b;

   assign back_a = {6'b0, s4_a_quot_ff} * 16'(PAIR_DIV);
   assign back_b = {6'b0, s4_b_quot_ff} * 16'(PAIR_DIV);
   assign rem_a  = s4_a_x_ff - back_a;
   assign rem_b  = s4_b_x_ff - back_b;

   always_comb begin
      pair_in[0] = '0;
      pair_in[1] = '0;
      pair_in[2] = '0;
      pair_in[3] = '0;
      if (s4_op_ff == OP_TWO) begin
         pair_in[0] = s4_a_x_ff;
      end else begin
         // a value under 100 has a zero upper pair and passes through whole
         if (s4_a_small_ff) begin
            pair_in[1] = s4_a_x_ff;
         end else begin
            pair_in[0] = {6'b0, s4_a_quot_ff};
            pair_in[1] = {9'b0, rem_a[6:0]};
         end
         if (s4_b_small_ff) begin
            pair_in[3] = s4_b_x_ff;
         end else begin
            pair_in[2] = {6'b0, s4_b_quot_ff};
            pair_in[3] = {9'b0, rem_b[6:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_op_ff <= s4_op_ff;
      for (int i = 0; i < 4; i++) begin
         s5_pair_ff[i] <= pair_in[i];
      end
   end

   // stage 6: tens digit of each pair; a low byte under ten takes the high byte
   logic        s6_valid_ff;
   logic [1:0]  s6_op_ff;
   logic [7:0]  s6_tens_ff [4];
   logic [4:0]  s6_quot_ff [4];
   logic [7:0]  s6_low_ff [4];
   logic        s6_under_ff [4];
   logic [15:0] digit_prod [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         digit_prod[i] = {8'b0, s5_pair_ff[i][7:0]} * {8'b0, DIGIT_RECIP};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_op_ff <= s5_op_ff;
      for (int i = 0; i < 4; i++) begin
         s6_low_ff[i]   <= s5_pair_ff[i][7:0];
         s6_quot_ff[i]  <= digit_prod[i][DIGIT_SHIFT+4:DIGIT_SHIFT];
         s6_under_ff[i] <= s5_pair_ff[i][7:0] < 8'(DIGIT_DIV);
         if (s5_pair_ff[i][7:0] < 8'(DIGIT_DIV)) begin
            s6_tens_ff[i] <= s5_pair_ff[i][15:8];
         end else begin
            s6_tens_ff[i] <= {3'b0, digit_prod[i][DIGIT_SHIFT+4:DIGIT_SHIFT]};
         end
      end
   end

   // stage 7: units digits, ASCII offset, zero fill and result register
   logic       s7_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic [7:0] chars [8];
   logic [7:0] units;
   logic [7:0] digit_back;

   always_comb begin
      units      = '0;
      digit_back = '0;
      for (int i = 0; i < 4; i++) begin
         digit_back = {3'b0, s6_quot_ff[i]} * 8'(DIGIT_DIV);
         if (s6_under_ff[i]) begin
            units = s6_low_ff[i];
         end else begin
            units = s6_low_ff[i] - digit_back;
         end
         chars[2*i]   = s6_tens_ff[i] + ASCII_ZERO;
         chars[2*i+1] = units + ASCII_ZERO;
      end
      rsp_in.char_0 = chars[0];
      rsp_in.char_1 = chars[1];
      rsp_in.char_2 = chars[2];
      rsp_in.char_3 = chars[3];
      rsp_in.char_4 = chars[4];
      rsp_in.char_5 = chars[5];
      rsp_in.char_6 = chars[6];
      rsp_in.char_7 = chars[7];
      case (s6_op_ff)
         OP_TWO: begin
            rsp_in.char_2     = '0;
            rsp_in.char_3     = '0;
            rsp_in.char_4     = '0;
            rsp_in.char_5     = '0;
            rsp_in.char_6     = '0;
            rsp_in.char_7     = '0;
            rsp_in.char_count = COUNT_TWO;
         end
         OP_FOUR: begin
            rsp_in.char_4     = '0;
            rsp_in.char_5     = '0;
            rsp_in.char_6     = '0;
            rsp_in.char_7     = '0;
            rsp_in.char_count = COUNT_FOUR;
         end
         default: begin
            rsp_in.char_count = COUNT_EIGHT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = s7_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
